[hw/rtl/dmlr_pkg.sv]
package dmlr_pkg;

  localparam int RAW_W   = 32;
  localparam int MONO_W  = 32;
  localparam int PCM_W   = 16;
  localparam int NUM_CH  = 8;
  localparam int CNT_W   = 4;
  localparam int FMT_W   = 3;
  localparam int STEP_W  = 30;
  localparam int CFG_IDX_W = 2;

  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S24 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 2'd2;

  // Q2.29 full scale
  localparam int Q_FRAC = 29;
  localparam logic [15:0] PCM_SCALE = 16'd32767;

  typedef logic signed [MONO_W-1:0] mono_t;

endpackage

[hw/rtl/downmix_linear_resampler.sv]
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata: sample_ch0..7, tuser: silent
// out_    | out | out_tvalid/out_tready| tdata: pcm_sample, tlast: last
// cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
// After acceptance a frame passes decode, averaging (bit-serial divide by the
// channel count) and the phase check, then multiply, clamp, PCM and emit per
// output, where emit waits on out_tready. A frame with no output ends at the check.
// in_tready is high only in idle; a new frame is taken only when the last is done.
// rst_n is synchronous; phase returns to 1.0 and the previous sample to 0.
module downmix_linear_resampler #(
  parameter int MAX_CHANNELS    = 8,
  parameter int PHASE_FRAC_BITS = 24,
  parameter int MAX_OUTPUTS     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [255:0]                        in_tdata,  // sample_ch0 .. sample_ch7
  input  logic [0:0]                          in_tuser,  // silent
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata, // pcm_sample
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [dmlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmlr_pkg::STEP_W-1:0]         cfg_wdata
);
  import dmlr_pkg::*;

  localparam int PH_W = 33;
  localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(64'd1 << PHASE_FRAC_BITS);
  localparam logic [PH_W-1:0] STEP_FLOOR =
      PH_W'(((64'd1 << PHASE_FRAC_BITS) + MAX_OUTPUTS - 1) / MAX_OUTPUTS);
  localparam int OC_W = $clog2(MAX_OUTPUTS + 1);
  localparam int PROD_W = MONO_W + 1 + PHASE_FRAC_BITS;
  localparam int CLMP_W = Q_FRAC + 1;
  localparam int PM_W = CLMP_W + 16;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIVIDE, S_CHECK, S_MUL, S_CLAMP, S_PCM, S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     chans_r;
  logic [FMT_W-1:0]     fmt_r;
  logic [STEP_W-1:0]    step_r;
  logic [PH_W-1:0]      ph_r, ph_nxt;
  mono_t                prev_r, prev_nxt;
  mono_t                cur_r, cur_nxt;
  logic [OC_W-1:0]      cnt_r, cnt_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 neg_r, neg_nxt;
  logic [CLMP_W-1:0]    cmag_r, cmag_nxt;
  logic                 cneg_r, cneg_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [PCM_W-1:0]     odata_r, odata_nxt;
  logic                 olast_r, olast_nxt;
  logic                 silent_r, silent_nxt;

  logic [CNT_W-1:0]     n_eff;
  logic [PH_W-1:0]      step_eff;
  logic                 in_acc;
  logic                 div_start;
  logic                 div_done;
  mono_t                mono;
  mono_t                lane_val [MAX_CHANNELS];
  logic signed [MONO_W:0] diff;
  logic [MONO_W:0]      dmag;
  logic [PROD_W:0]      rq;
  logic signed [MONO_W+2:0] interp;
  logic [PM_W-1:0]      pm;
  logic [15:0]          pmag;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_comb begin
    if (chans_r == '0) n_eff = CNT_W'(1);
    else if (chans_r > CNT_W'(MAX_CHANNELS)) n_eff = CNT_W'(MAX_CHANNELS);
    else n_eff = chans_r;
    step_eff = (PH_W'(step_r) < STEP_FLOOR) ? STEP_FLOOR : PH_W'(step_r);
  end

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    dmlr_lane u_lane (
      .clk   (clk),
      .load  (in_acc),
      .en    (!in_tuser[0] && (CNT_W'(g) < n_eff)),
      .fmt   (fmt_r),
      .raw   (in_tdata[g*RAW_W +: RAW_W]),
      .val_r (lane_val[g])
    );
  end

  dmlr_merge #(.MAX_CHANNELS(MAX_CHANNELS)) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .n      (n_eff),
    .lane   (lane_val),
    .done_r (div_done),
    .mono_r (mono)
  );

  assign div_start = (state_r == S_DECODE);

  always_comb begin
    diff = {cur_r[MONO_W-1], cur_r} - {prev_r[MONO_W-1], prev_r};
    dmag = diff[MONO_W] ? (MONO_W+1)'(-diff) : (MONO_W+1)'(diff);
    rq   = ({1'b0, prod_r} + (PROD_W+1)'(PHASE_ONE >> 1)) >> PHASE_FRAC_BITS;
    interp = (MONO_W+3)'(prev_r) + (neg_r ? -(MONO_W+3)'(rq) : (MONO_W+3)'(rq));
    pm   = PM_W'(cmag_r) * PM_W'(PCM_SCALE) + (PM_W'(1) << (Q_FRAC - 1));
    pmag = pm[Q_FRAC +: 16];
  end

  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    neg_nxt    = neg_r;
    cmag_nxt   = cmag_r;
    cneg_nxt   = cneg_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    silent_nxt = silent_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          silent_nxt = in_tuser[0];
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: state_nxt = S_DIVIDE;
      S_DIVIDE: begin
        if (div_done) begin
          cur_nxt   = silent_r ? mono_t'(0) : mono;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ph_r < PHASE_ONE && cnt_r < OC_W'(MAX_OUTPUTS)) begin
          state_nxt = S_MUL;
        end else begin
          ph_nxt    = (ph_r >= PHASE_ONE) ? ph_r - PHASE_ONE : '0;
          prev_nxt  = cur_r;
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(dmag) * PROD_W'(ph_r[PHASE_FRAC_BITS-1:0]);
        neg_nxt   = diff[MONO_W];
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cneg_nxt = interp[MONO_W+2];
        if (interp > (MONO_W+3)'(64'sd1 << Q_FRAC)) cmag_nxt = CLMP_W'(1) << Q_FRAC;
        else if (interp < -((MONO_W+3)'(64'sd1 << Q_FRAC))) cmag_nxt = CLMP_W'(1) << Q_FRAC;
        else if (interp[MONO_W+2]) cmag_nxt = CLMP_W'(-interp);
        else cmag_nxt = CLMP_W'(interp);
        state_nxt = S_PCM;
      end
      S_PCM: begin
        odata_nxt  = cneg_r ? PCM_W'(~pmag + 16'd1) : pmag;
        olast_nxt  = (ph_r + step_eff >= PHASE_ONE) || (cnt_r == OC_W'(MAX_OUTPUTS - 1));
        ovalid_nxt = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          ph_nxt     = ph_r + step_eff;
          cnt_nxt    = cnt_r + 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ph_r     <= PHASE_ONE;
      prev_r   <= '0;
      ovalid_r <= 1'b0;
      chans_r  <= CNT_W'(1);
      fmt_r    <= FMT_S16;
      step_r   <= STEP_W'(30'd16777216);
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      prev_r   <= prev_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: chans_r <= cfg_wdata[CNT_W-1:0];
          REG_SAMPLE_FORMAT: fmt_r   <= cfg_wdata[FMT_W-1:0];
          REG_STEP_RATIO:    step_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    neg_r    <= neg_nxt;
    cmag_r   <= cmag_nxt;
    cneg_r   <= cneg_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
    silent_r <= silent_nxt;
  end

endmodule

[hw/rtl/dmlr_lane.sv]
module dmlr_lane (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        en,
  input  logic [dmlr_pkg::FMT_W-1:0]  fmt,
  input  logic [dmlr_pkg::RAW_W-1:0]  raw,
  output dmlr_pkg::mono_t             val_r
);
  import dmlr_pkg::*;

  logic [8:0]  u8v;
  logic [7:0]  e;
  logic [7:0]  sh;
  logic [32:0] sig;
  logic [32:0] mag;
  logic [31:0] m32;
  logic        nan;
  mono_t       fval;
  mono_t       val_nxt;

  always_comb begin
    e   = raw[30:23];
    sig = {9'b0, 1'b1, raw[22:0]};
    nan = 1'b0;
    mag = '0;
    sh  = '0;
    if (e == 8'd255) begin
      nan = (raw[22:0] != 23'd0);
      mag = 33'h1_0000_0000;
    end else if (e == 8'd0) begin
      mag = '0;
    end else if (e >= 8'd121) begin
      sh = e - 8'd121;
      if (sh > 8'd8) mag = 33'h1_0000_0000;
      else mag = sig << sh[3:0];
    end else begin
      sh = 8'd121 - e;
      if (sh >= 8'd25) mag = '0;
      else mag = (sig + (33'd1 << (sh[4:0] - 5'd1))) >> sh[4:0];
    end
    if (raw[31]) begin
      m32  = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
      fval = mono_t'(~m32 + 32'd1);
    end else begin
      m32  = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      fval = mono_t'(m32);
    end
    if (nan) fval = '0;
  end

  always_comb begin
    u8v = {1'b0, raw[7:0]} - 9'd128;
    case (fmt)
      FMT_U8:  val_nxt = {u8v[8], u8v, 22'b0};
      FMT_S16: val_nxt = {{2{raw[15]}}, raw[15:0], 14'b0};
      FMT_S24: val_nxt = {{2{raw[23]}}, raw[23:0], 6'b0};
      FMT_S32: val_nxt = {{2{raw[31]}}, raw[31:2]};
      FMT_F32: val_nxt = fval;
      default: val_nxt = '0;
    endcase
    if (!en) val_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (load) val_r <= val_nxt;
  end

endmodule

[hw/rtl/dmlr_merge.sv]
module dmlr_merge #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dmlr_pkg::CNT_W-1:0] n,
  input  dmlr_pkg::mono_t            lane [MAX_CHANNELS],
  output logic                       done_r,
  output dmlr_pkg::mono_t            mono_r
);
  import dmlr_pkg::*;

  localparam int SUM_W = MONO_W + $clog2(MAX_CHANNELS) + 1;
  localparam int NUM_W = SUM_W + 1;
  localparam int ITER_W = $clog2(NUM_W + 1);

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_mag;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [CNT_W:0]          rem_r, rem_nxt, rem_sh;
  logic [ITER_W-1:0]       iter_r, iter_nxt;
  logic                    neg_r, neg_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_nxt;
  mono_t                   mono_nxt;

  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) sum = sum + SUM_W'(lane[i]);
    sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  end

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    iter_nxt = iter_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mono_nxt = mono_r;
    rem_sh   = {rem_r[CNT_W-1:0], num_r[NUM_W-1]};
    if (start) begin
      num_nxt  = NUM_W'(sum_mag) + NUM_W'(n >> 1);
      neg_nxt  = sum[SUM_W-1];
      rem_nxt  = '0;
      iter_nxt = ITER_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, n}) begin
        rem_nxt = rem_sh - {1'b0, n};
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      iter_nxt = iter_r - 1'b1;
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        mono_nxt = neg_r ? mono_t'(~num_nxt[MONO_W-1:0] + 1'b1) : mono_t'(num_nxt[MONO_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    iter_r <= iter_nxt;
    neg_r  <= neg_nxt;
    mono_r <= mono_nxt;
  end

endmodule

[hw/rtl/dmlr_checker.sv]
module dmlr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out_tvalid dropped");

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during output");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("back to back accept");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule

bind downmix_linear_resampler dmlr_checker u_dmlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
